// ===== hdl/tkn_pkg.sv =====
`timescale 1ns / 1ps

package tkn_pkg;

    // Default widths and fixed field widths
    localparam int TKN_POSITION_BITS = 24;
    localparam int TKN_LENGTH_BITS   = 16;
    localparam int LINE_BITS         = 16;
    localparam int KIND_BITS         = 3;
    localparam int QUEUE_DEPTH       = 4;
    localparam int APB_ADDR_BITS     = 3;

    // Register map (word index)
    localparam logic [APB_ADDR_BITS-3:0] REG_FIRST_LINE = '0;

    // Byte codes
    localparam logic [7:0] CHR_LPAREN = 8'h28;
    localparam logic [7:0] CHR_RPAREN = 8'h29;
    localparam logic [7:0] CHR_SEMI   = 8'h3B;
    localparam logic [7:0] CHR_PLUS   = 8'h2B;
    localparam logic [7:0] CHR_UNDER  = 8'h5F;
    localparam logic [7:0] CHR_LF     = 8'h0A;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_INT    = 3'd0,
        KIND_WORD   = 3'd1,
        KIND_LPAREN = 3'd2,
        KIND_RPAREN = 3'd3,
        KIND_SEMI   = 3'd4,
        KIND_PLUS   = 3'd5,
        KIND_ERROR  = 3'd6
    } token_kind_t;

    typedef enum logic [1:0] {
        MODE_FRESH = 2'd0,
        MODE_IDLE  = 2'd1,
        MODE_INT   = 2'd2,
        MODE_WORD  = 2'd3
    } scan_mode_t;

    typedef enum logic [1:0] {
        CLS_SPACE,
        CLS_DIGIT,
        CLS_IDENT,
        CLS_OTHER
    } char_class_t;

    // Queue write strobes from the scanner
    typedef struct packed {
        logic wr0;
        logic wr1;
    } push_ctrl_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t cls;
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
            cls = CLS_SPACE;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            cls = CLS_DIGIT;
        end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
                     || c == CHR_UNDER) begin
            cls = CLS_IDENT;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

    function automatic token_kind_t single_kind(input logic [7:0] c);
        token_kind_t k;
        case (c)
            CHR_LPAREN: k = KIND_LPAREN;
            CHR_RPAREN: k = KIND_RPAREN;
            CHR_SEMI:   k = KIND_SEMI;
            CHR_PLUS:   k = KIND_PLUS;
            default:    k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/tkn_scan.sv =====
`timescale 1ns / 1ps

module tkn_scan import tkn_pkg::*; #(
    parameter int POSITION_BITS = TKN_POSITION_BITS,
    parameter int LENGTH_BITS   = TKN_LENGTH_BITS,
    localparam int TOK_W = KIND_BITS + LINE_BITS + POSITION_BITS + LENGTH_BITS + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_char_byte,
    input  logic                 s_end_of_source,
    input  logic [LINE_BITS-1:0] first_line,
    input  logic                 q_space2,
    output push_ctrl_t           push,
    output logic [TOK_W-1:0]     tok0,
    output logic [TOK_W-1:0]     tok1
);

    // Input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] chr_reg;
    logic       eos_reg;

    // Scanner state
    scan_mode_t               mode_reg, mode_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    logic                     fire;
    char_class_t              cls;
    scan_mode_t               mode_eff, mode_mid;
    logic [LINE_BITS-1:0]     cur_line;
    logic [POSITION_BITS-1:0] cur_pos;
    logic                     cont, e_pend, e_single, e_flush, e_sec;
    token_kind_t              pend_kind, sec_kind, flush_kind;
    logic [POSITION_BITS-1:0] start_mid, sec_pos;
    logic [LENGTH_BITS-1:0]   len_mid, sec_len;
    logic [TOK_W-1:0]         pend_tok;

    assign fire    = in_vld_reg && q_space2;
    assign s_ready = !in_vld_reg || fire;

    // Input register load and drain
    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
        if (s_valid && s_ready) begin
            chr_reg <= s_char_byte;
            eos_reg <= s_end_of_source;
        end
    end

    // Per-byte token logic
    always_comb begin
        cls       = classify(chr_reg);
        mode_eff  = (mode_reg == MODE_FRESH) ? MODE_IDLE : mode_reg;
        cur_line  = (mode_reg == MODE_FRESH) ? first_line : line_reg;
        cur_pos   = (mode_reg == MODE_FRESH) ? '0 : pos_reg;

        // newline counts before any token this byte ends
        line_next = cur_line;
        if (chr_reg == CHR_LF && cur_line != '1) begin
            line_next = cur_line + 1'b1;
        end

        cont = (mode_eff == MODE_INT && cls == CLS_DIGIT) ||
               (mode_eff == MODE_WORD && (cls == CLS_DIGIT || cls == CLS_IDENT));

        e_pend    = 1'b0;
        e_single  = 1'b0;
        mode_mid  = mode_eff;
        start_mid = start_reg;
        len_mid   = len_reg;
        pend_kind = (mode_eff == MODE_INT) ? KIND_INT : KIND_WORD;

        if (cont) begin
            if (len_reg != '1) begin
                len_mid = len_reg + 1'b1;
            end
        end else begin
            if (mode_eff == MODE_INT || mode_eff == MODE_WORD) begin
                e_pend   = 1'b1;
                mode_mid = MODE_IDLE;
            end
            case (cls)
                CLS_SPACE: begin
                end
                CLS_DIGIT: begin
                    mode_mid  = MODE_INT;
                    start_mid = cur_pos;
                    len_mid   = LENGTH_BITS'(1);
                end
                CLS_IDENT: begin
                    mode_mid  = MODE_WORD;
                    start_mid = cur_pos;
                    len_mid   = LENGTH_BITS'(1);
                end
                default: begin
                    e_single = 1'b1;
                end
            endcase
        end

        pos_next = (cur_pos != '1) ? cur_pos + 1'b1 : cur_pos;

        // end of source flushes a pending integer or word
        e_flush    = eos_reg && (mode_mid == MODE_INT || mode_mid == MODE_WORD);
        flush_kind = (mode_mid == MODE_INT) ? KIND_INT : KIND_WORD;
        mode_next  = mode_mid;
        start_next = start_mid;
        len_next   = len_mid;
        if (eos_reg) begin
            mode_next  = MODE_FRESH;
            start_next = '0;
            len_next   = '0;
        end

        // second token: single-byte token or flushed one, never both
        e_sec    = e_single || e_flush;
        sec_kind = e_single ? single_kind(chr_reg) : flush_kind;
        sec_pos  = e_single ? cur_pos : start_mid;
        sec_len  = e_single ? LENGTH_BITS'(1) : len_mid;

        pend_tok = {pend_kind, line_next, start_reg, len_reg, !e_sec};
        tok1     = {sec_kind, line_next, sec_pos, sec_len, 1'b1};
        tok0     = e_pend ? pend_tok : tok1;
        push.wr0 = fire && (e_pend || e_sec);
        push.wr1 = fire && e_pend && e_sec;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_FRESH;
            start_reg <= '0;
            len_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
            pos_reg   <= '0;
        end else if (fire) begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
            pos_reg   <= pos_next;
        end
    end

    // Checks
    a_eos_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && eos_reg) |=> (mode_reg == MODE_FRESH))
        else $error("scanner not back to fresh after end of source");

    a_wr_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.wr1 |-> push.wr0)
        else $error("second token written without first");

    a_push_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        push.wr0 |-> (in_vld_reg && q_space2))
        else $error("token pushed without a consumed item");

endmodule

// ===== hdl/tkn_queue.sv =====
`timescale 1ns / 1ps

module tkn_queue import tkn_pkg::*; #(
    parameter int POSITION_BITS = TKN_POSITION_BITS,
    parameter int LENGTH_BITS   = TKN_LENGTH_BITS,
    localparam int TOK_W = KIND_BITS + LINE_BITS + POSITION_BITS + LENGTH_BITS + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  push_ctrl_t       push,
    input  logic [TOK_W-1:0] tok0,
    input  logic [TOK_W-1:0] tok1,
    output logic             q_space2,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [TOK_W-1:0] q_out
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [TOK_W-1:0] q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] tail_p1;
    logic             pop;

    assign tail_p1  = tail_reg + 1'b1;
    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != '0);
    assign q_space2 = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign q_out    = q_mem_reg[head_reg];

    // Pointer and fill count update
    always_comb begin
        head_next  = pop ? head_reg + 1'b1 : head_reg;
        tail_next  = tail_reg + PTR_W'(push.wr0) + PTR_W'(push.wr1);
        count_next = count_reg + CNT_W'(push.wr0) + CNT_W'(push.wr1) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Token storage, up to two writes per cycle
    always_ff @(posedge aclk) begin
        if (push.wr0) begin
            q_mem_reg[tail_reg] <= tok0;
        end
        if (push.wr1) begin
            q_mem_reg[tail_p1] <= tok1;
        end
    end

    // Checks
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("token queue overflow");

    a_room_two: assert property (@(posedge aclk) disable iff (!aresetn)
        push.wr1 |-> (count_reg <= CNT_W'(QUEUE_DEPTH - 2)))
        else $error("two tokens written without room");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (!push.wr0 && !pop) |=> $stable(count_reg))
        else $error("fill count moved without push or pop");

endmodule

// ===== hdl/byte_stream_tokenizer_core.sv =====
`timescale 1ns / 1ps
// A byte waits in the input register until its tokens enter the queue on m_*.
// Throughput: one byte per cycle; a byte that ends one token and emits another
// gives two tokens, which leave one per cycle while m_ready is high, through a
// four-entry token queue; the input stalls while it has under two free entries.
// Reset (aresetn low, synchronous): queue empty, scanner fresh, first_line = 1.

module byte_stream_tokenizer_core import tkn_pkg::*; #(
    parameter int POSITION_BITS = TKN_POSITION_BITS,
    parameter int LENGTH_BITS   = TKN_LENGTH_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // byte input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_char_byte,
    input  logic                     s_end_of_source,
    // token output
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [KIND_BITS-1:0]     m_token_kind,
    output logic [LINE_BITS-1:0]     m_token_line,
    output logic [POSITION_BITS-1:0] m_token_position,
    output logic [LENGTH_BITS-1:0]   m_token_length,
    output logic                     m_last_of_run,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int TOK_W = KIND_BITS + LINE_BITS + POSITION_BITS + LENGTH_BITS + 1;

    logic [LINE_BITS-1:0] first_line_reg;
    logic                 reg_hit;
    push_ctrl_t           push;
    logic [TOK_W-1:0]     tok0, tok1, q_out;
    logic                 q_space2;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_BITS-1:2] == REG_FIRST_LINE);
    assign prdata  = reg_hit ? 32'(first_line_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_line_reg <= LINE_BITS'(1);
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            first_line_reg <= pwdata[LINE_BITS-1:0];
        end
    end

    tkn_scan #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_scan (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_byte    (s_char_byte),
        .s_end_of_source(s_end_of_source),
        .first_line     (first_line_reg),
        .q_space2       (q_space2),
        .push           (push),
        .tok0           (tok0),
        .tok1           (tok1)
    );

    tkn_queue #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .tok0    (tok0),
        .tok1    (tok1),
        .q_space2(q_space2),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .q_out   (q_out)
    );

    // Token field unpack
    assign m_token_kind     = q_out[TOK_W-1 -: KIND_BITS];
    assign m_token_line     = q_out[TOK_W-KIND_BITS-1 -: LINE_BITS];
    assign m_token_position = q_out[LENGTH_BITS+POSITION_BITS : LENGTH_BITS+1];
    assign m_token_length   = q_out[LENGTH_BITS:1];
    assign m_last_of_run    = q_out[0];

endmodule

// ===== bench/tokenizer_checker.sv =====
`timescale 1ns / 1ps

// Watches both item channels and the register port, keeps its own copy of the
// scanner state and checks every token against the predicted one.
module tokenizer_checker import tkn_pkg::*; #(
    parameter int POSITION_BITS = TKN_POSITION_BITS,
    parameter int LENGTH_BITS   = TKN_LENGTH_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [7:0]               s_char_byte,
    input  logic                     s_end_of_source,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [KIND_BITS-1:0]     m_token_kind,
    input  logic [LINE_BITS-1:0]     m_token_line,
    input  logic [POSITION_BITS-1:0] m_token_position,
    input  logic [LENGTH_BITS-1:0]   m_token_length,
    input  logic                     m_last_of_run,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    input  logic [31:0]              prdata,
    input  logic                     pready,
    output int                       tokens_outstanding,
    output int                       fail_count
);

    typedef struct packed {
        token_kind_t              kind;
        logic [LINE_BITS-1:0]     line;
        logic [POSITION_BITS-1:0] pos;
        logic [LENGTH_BITS-1:0]   len;
        logic                     last;
    } token_t;

    // Scanner copy
    logic [LINE_BITS-1:0]     first_line;
    scan_mode_t               mode;
    logic [POSITION_BITS-1:0] tok_start;
    logic [LENGTH_BITS-1:0]   tok_len;
    logic [LINE_BITS-1:0]     line_cnt;
    logic [POSITION_BITS-1:0] pos_cnt;

    token_t tokens_due[$];
    token_t byte_tokens[$];
    token_t want;
    int     mismatches = 0;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // letters and underscore: may start a word
    function automatic logic is_ident(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CHR_UNDER;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void emit(input token_kind_t kind,
                                 input logic [POSITION_BITS-1:0] start,
                                 input logic [LENGTH_BITS-1:0] len);
        token_t t;
        t.kind = kind;
        t.line = line_cnt;
        t.pos  = start;
        t.len  = len;
        t.last = 1'b0;
        byte_tokens.push_back(t);
    endfunction

    function automatic void emit_pending();
        if (mode == MODE_INT) begin
            emit(KIND_INT, tok_start, tok_len);
        end else begin
            emit(KIND_WORD, tok_start, tok_len);
        end
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            mismatches++;
            $display("%0t %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    // Advance the scanner copy by one byte, queue the tokens it gives
    task automatic scan_byte(input logic [7:0] c, input logic eos);
        logic [POSITION_BITS-1:0] here;
        byte_tokens.delete();
        // first byte of a source reloads the counters
        if (mode == MODE_FRESH) begin
            line_cnt = first_line;
            pos_cnt  = '0;
            mode     = MODE_IDLE;
        end
        here = pos_cnt;
        // newline counts before any token it ends goes out
        if (c == CHR_LF && line_cnt != '1) line_cnt++;

        if ((mode == MODE_INT && is_digit(c)) ||
            (mode == MODE_WORD && (is_digit(c) || is_ident(c)))) begin
            if (tok_len != '1) tok_len++;
        end else begin
            if (mode != MODE_IDLE) begin
                emit_pending();
                mode = MODE_IDLE;
            end
            if (is_digit(c)) begin
                mode      = MODE_INT;
                tok_start = here;
                tok_len   = LENGTH_BITS'(1);
            end else if (is_ident(c)) begin
                mode      = MODE_WORD;
                tok_start = here;
                tok_len   = LENGTH_BITS'(1);
            end else if (!is_blank(c)) begin
                case (c)
                    CHR_LPAREN: emit(KIND_LPAREN, here, LENGTH_BITS'(1));
                    CHR_RPAREN: emit(KIND_RPAREN, here, LENGTH_BITS'(1));
                    CHR_SEMI:   emit(KIND_SEMI, here, LENGTH_BITS'(1));
                    CHR_PLUS:   emit(KIND_PLUS, here, LENGTH_BITS'(1));
                    default:    emit(KIND_ERROR, here, LENGTH_BITS'(1));
                endcase
            end
        end

        if (pos_cnt != '1) pos_cnt++;

        // end of source flushes a pending int or word
        if (eos) begin
            if (mode != MODE_IDLE) emit_pending();
            mode      = MODE_FRESH;
            tok_start = '0;
            tok_len   = '0;
        end

        if (byte_tokens.size() != 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
        foreach (byte_tokens[i]) tokens_due.push_back(byte_tokens[i]);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            first_line = 16'd1;
            mode       = MODE_FRESH;
            tok_start  = '0;
            tok_len    = '0;
            line_cnt   = 16'd1;
            pos_cnt    = '0;
            tokens_due.delete();
        end else begin
            // register port: follow writes, check reads
            if (psel && penable && pready && paddr[APB_ADDR_BITS-1:2] == REG_FIRST_LINE) begin
                if (pwrite) begin
                    first_line = pwdata[LINE_BITS-1:0];
                end else begin
                    check_field("prdata", 64'({16'h0, first_line}), 64'(prdata));
                end
            end

            if (s_valid && s_ready) scan_byte(s_char_byte, s_end_of_source);

            // token out: compare with the oldest prediction
            if (m_valid && m_ready) begin
                if (tokens_due.size() == 0) begin
                    mismatches++;
                    $display({"%0t unexpected token: expected none, ",
                              "actual kind %0d line %0d position %0d length %0d"},
                             $time, m_token_kind, m_token_line, m_token_position,
                             m_token_length);
                end else begin
                    want = tokens_due.pop_front();
                    check_field("token_kind", 64'(want.kind), 64'(m_token_kind));
                    check_field("token_line", 64'(want.line), 64'(m_token_line));
                    check_field("token_position", 64'(want.pos), 64'(m_token_position));
                    check_field("token_length", 64'(want.len), 64'(m_token_length));
                    check_field("last_of_run", 64'(want.last), 64'(m_last_of_run));
                end
            end
        end
        tokens_outstanding <= tokens_due.size();
        fail_count         <= mismatches;
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tkn_pkg::*;

    localparam int POSITION_BITS   = TKN_POSITION_BITS;
    localparam int LENGTH_BITS     = TKN_LENGTH_BITS;
    localparam int LIMIT_CYCLES    = 1_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASE_BYTES     = 200;
    localparam int PHASES          = 6;
    localparam logic [APB_ADDR_BITS-1:0] FIRST_LINE_ADDR = {REG_FIRST_LINE, 2'b00};

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [7:0]               s_char_byte;
    logic                     s_end_of_source;
    logic                     m_valid;
    logic                     m_ready;
    logic [KIND_BITS-1:0]     m_token_kind;
    logic [LINE_BITS-1:0]     m_token_line;
    logic [POSITION_BITS-1:0] m_token_position;
    logic [LENGTH_BITS-1:0]   m_token_length;
    logic                     m_last_of_run;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    int   tokens_outstanding;
    int   fail_count;
    int   cycle_count;
    logic burst;
    logic hold_req;

    logic [7:0] src_bytes[$];

    // Opening sequence: {end_of_source, byte}
    logic [8:0] opening [27] = '{
        {1'b0, "_"}, {1'b0, "a"}, {1'b0, "9"}, {1'b0, "("},   // word then paren
        {1'b0, "1"}, {1'b0, "2"}, {1'b0, ")"},                // int then paren
        {1'b0, ";"}, {1'b0, "+"}, {1'b0, 8'h00}, {1'b0, 8'hFF},
        {1'b0, "7"}, {1'b0, 8'h0A},                           // int ended by newline
        {1'b0, 8'h09}, {1'b0, 8'h0B}, {1'b0, 8'h0C}, {1'b0, 8'h0D}, {1'b0, " "},
        {1'b0, "Z"}, {1'b1, "z"},                             // word flushed at end
        {1'b1, "4"},                                          // one-byte source
        {1'b1, "+"},
        {1'b1, " "},                                          // source with no token
        {1'b0, 8'h08}, {1'b0, 8'h0E}, {1'b0, "3"}, {1'b1, "x"}
    };

    logic [15:0] line_setting [PHASES] = '{16'd0, 16'hFFFF, 16'hFFFE, 16'h5A5A, 16'd1, 16'h8000};

    byte_stream_tokenizer_core #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_dut (.*);

    tokenizer_checker #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [7:0] ident_char(input logic with_digits);
        int r;
        r = $urandom_range(0, with_digits ? 62 : 52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        if (r == 52) return CHR_UNDER;
        return 8'("0" + r - 53);
    endfunction

    // One item on the byte channel, held until accepted
    task automatic send_byte(input logic [7:0] c, input logic eos);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_char_byte     <= c;
        s_end_of_source <= eos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop sending and wait for every predicted token
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tokens_outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Send the built source, end_of_source on its last byte
    task automatic send_source(input int pause_at);
        int i;
        for (i = 0; i < src_bytes.size(); i++) begin
            if (i == pause_at) drain_results();
            send_byte(src_bytes[i], i == src_bytes.size() - 1);
        end
    endtask

    // Setup cycle, then access cycle; psel and penable are dropped afterwards
    task automatic apb_access(input logic write, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= FIRST_LINE_ADDR;
        pwdata  <= {16'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Random source: mostly well-formed tokens, some junk
    task automatic build_source();
        int target;
        int n;
        src_bytes.delete();
        target = $urandom_range(4, 40);
        if ($urandom_range(0, 9) == 0) begin
            repeat (target) src_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            while (src_bytes.size() < target) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 30)
                                                         : $urandom_range(1, 6);
                        repeat (n) src_bytes.push_back(8'("0" + $urandom_range(0, 9)));
                    end
                    3, 4, 5: begin
                        n = $urandom_range(0, 9);
                        src_bytes.push_back(ident_char(1'b0));
                        repeat (n) src_bytes.push_back(ident_char(1'b1));
                    end
                    6: begin
                        case ($urandom_range(0, 3))
                            0:       src_bytes.push_back(CHR_LPAREN);
                            1:       src_bytes.push_back(CHR_RPAREN);
                            2:       src_bytes.push_back(CHR_SEMI);
                            default: src_bytes.push_back(CHR_PLUS);
                        endcase
                    end
                    7: begin
                        n = $urandom_range(1, 3);
                        repeat (n) begin
                            if ($urandom_range(0, 2) == 0) begin
                                src_bytes.push_back(" ");
                            end else begin
                                src_bytes.push_back(8'($urandom_range(9, 13)));
                            end
                        end
                    end
                    8:       src_bytes.push_back(8'($urandom_range(0, 255)));
                    default: src_bytes.push_back(CHR_LF);
                endcase
            end
        end
    endtask

    // Token receiver: random stalls, one long hold-off on request
    initial begin
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req <= 1'b0;
            end
            gap = burst ? 0 : $urandom_range(0, 11);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Byte sender and register writes
    initial begin
        int p;
        int sent;
        int pause_at;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_char_byte     <= 8'h00;
        s_end_of_source <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        burst           <= 1'b0;
        hold_req        <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_access(1'b0, 16'h0);

        foreach (opening[i]) send_byte(opening[i][7:0], opening[i][8]);

        // Random phases, each under its own first_line
        for (p = 0; p < PHASES; p++) begin
            drain_results();
            apb_access(1'b1, (p == 3) ? 16'($urandom_range(0, 65535)) : line_setting[p]);
            apb_access(1'b0, 16'h0);
            burst <= (p == 1 || p == 2 || p == 4);
            if (p == 2) hold_req <= 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_source();
                // one pause mid-source until all tokens are out
                pause_at = (p == 3 && sent == 0) ? src_bytes.size() / 2 : -1;
                send_source(pause_at);
                sent += src_bytes.size();
            end
        end

        burst <= 1'b0;
        drain_results();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
